/* rtl/gnet_pkg.sv */
// gnet_pkg: item types, command and status codes, controller states
// for the graph node and edge table; no dependencies
`default_nettype none
package gnet_pkg;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] node_id;
		logic signed [31:0] node_weight;
		logic signed [31:0] from_node;
		logic signed [31:0] to_node;
		logic signed [31:0] edge_weight;
	} in_t;

	typedef struct packed {
		logic [3:0] status;
		logic       edge_seen_before;
		logic [7:0] node_count;
		logic [8:0] edge_count;
	} out_t;

	localparam logic [1:0] CMD_ADD_NODE = 2'd0;
	localparam logic [1:0] CMD_REM_NODE = 2'd1;
	localparam logic [1:0] CMD_ADD_EDGE = 2'd2;
	localparam logic [1:0] CMD_REM_EDGE = 2'd3;

	localparam logic [3:0] ST_DONE      = 4'd0;
	localparam logic [3:0] ST_DUP_NODE  = 4'd1;
	localparam logic [3:0] ST_LIMIT     = 4'd2;
	localparam logic [3:0] ST_NOT_FOUND = 4'd3;
	localparam logic [3:0] ST_UNDER_TWO = 4'd4;
	localparam logic [3:0] ST_BOTH_MISS = 4'd5;
	localparam logic [3:0] ST_FROM_MISS = 4'd6;
	localparam logic [3:0] ST_TO_MISS   = 4'd7;
	localparam logic [3:0] ST_EDGE_FULL = 4'd8;

	localparam logic [6:0] NODE_LIMIT_RESET   = 7'd100;
	localparam int         MIN_NODES_FOR_EDGE = 2;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FIN
	} fsm_t;

endpackage
`default_nettype wire

/* rtl/graph_node_edge_table.sv */
// graph_node_edge_table: node and edge tables held in rotating cell chains
// flow: accept in idle, scan the entries (node count for node commands, edge count for
// remove edge, both tables in parallel for add edge, none if refused early), then finish
// registers the result once the output slot is free; one item at a time
// reset clears counts, limit to 100 and handshake state; entries are not cleared
// uses gnet_pkg, gnet_ring
`default_nettype none
module graph_node_edge_table #(
	parameter int MAX_NODES = 128,
	parameter int MAX_EDGES = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire gnet_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output gnet_pkg::out_t     out_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [6:0]    cfg_data
);

	localparam int NIW = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int EIW = $clog2(MAX_EDGES);
	localparam int ECW = $clog2(MAX_EDGES + 1);

	gnet_pkg::fsm_t state_q, state_d;
	gnet_pkg::in_t  cmd_q;
	gnet_pkg::out_t out_q, res;
	logic           out_valid_q;
	logic [6:0]     limit_q;
	logic [NCW-1:0] n_cnt_q, n_left_q;
	logic [ECW-1:0] e_cnt_q, e_left_q;
	logic           early_q, found_n_q, hit_a_q, hit_b_q, found_e_q;

	logic [63:0]    n_head;
	logic [95:0]    e_head;
	logic           n_busy, e_busy, n_match, n_drop, e_full3, e_pair, e_hit, e_drop;
	logic           in_go, fin_go, n_app, e_app, lim, under2;
	logic           n_rot, n_wr, e_rot, e_wr;
	logic [NIW-1:0] n_idx;
	logic [EIW-1:0] e_idx;
	logic [63:0]    n_wdata;
	logic [95:0]    e_wdata;

	assign in_ready  = (state_q == gnet_pkg::FSM_IDLE);
	assign in_go     = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign fin_go    = (state_q == gnet_pkg::FSM_FIN) && (!out_valid_q || out_ready);

	assign lim    = (32'(n_cnt_q) > 32'(limit_q)) || (32'(n_cnt_q) >= 32'(MAX_NODES));
	assign under2 = 32'(n_cnt_q) < 32'(gnet_pkg::MIN_NODES_FOR_EDGE);

	assign n_busy  = n_left_q != '0;
	assign e_busy  = e_left_q != '0;
	assign n_match = n_head == {cmd_q.node_id, cmd_q.node_weight};
	assign n_drop  = n_busy && cmd_q.cmd == gnet_pkg::CMD_REM_NODE && n_match && !found_n_q;
	assign e_full3 = e_head == {cmd_q.from_node, cmd_q.to_node, cmd_q.edge_weight};
	assign e_pair  = e_head[95:32] == {cmd_q.from_node, cmd_q.to_node};
	assign e_hit   = (cmd_q.cmd == gnet_pkg::CMD_REM_EDGE) ? e_pair : e_full3;
	assign e_drop  = e_busy && cmd_q.cmd == gnet_pkg::CMD_REM_EDGE && e_pair && !found_e_q;

	always_comb begin
		res                  = '0;
		res.node_count       = 8'(n_cnt_q);
		res.edge_count       = 9'(e_cnt_q);
		n_app                = 1'b0;
		e_app                = 1'b0;
		unique case (cmd_q.cmd)
			gnet_pkg::CMD_ADD_NODE: begin
				if (early_q) begin
					res.status = gnet_pkg::ST_LIMIT;
				end else if (found_n_q) begin
					res.status = gnet_pkg::ST_DUP_NODE;
				end else begin
					n_app          = 1'b1;
					res.status     = gnet_pkg::ST_DONE;
					res.node_count = 8'(n_cnt_q + 1'b1);
				end
			end
			gnet_pkg::CMD_REM_NODE: begin
				res.status = found_n_q ? gnet_pkg::ST_DONE : gnet_pkg::ST_NOT_FOUND;
			end
			gnet_pkg::CMD_ADD_EDGE: begin
				res.edge_seen_before = found_e_q && !early_q;
				priority if (early_q) begin
					res.status = gnet_pkg::ST_UNDER_TWO;
				end else if (!hit_a_q && !hit_b_q) begin
					res.status = gnet_pkg::ST_BOTH_MISS;
				end else if (!hit_a_q) begin
					res.status = gnet_pkg::ST_FROM_MISS;
				end else if (!hit_b_q) begin
					res.status = gnet_pkg::ST_TO_MISS;
				end else if (32'(e_cnt_q) >= 32'(MAX_EDGES)) begin
					res.status = gnet_pkg::ST_EDGE_FULL;
				end else begin
					e_app          = 1'b1;
					res.status     = gnet_pkg::ST_DONE;
					res.edge_count = 9'(e_cnt_q + 1'b1);
				end
			end
			gnet_pkg::CMD_REM_EDGE: begin
				res.status = found_e_q ? gnet_pkg::ST_DONE : gnet_pkg::ST_NOT_FOUND;
			end
			default: res.status = gnet_pkg::ST_DONE;
		endcase
	end

	// rotate: popped head goes back at the tail unless it is the removed entry
	assign n_rot   = (state_q == gnet_pkg::FSM_SCAN) && n_busy;
	assign n_wr    = n_rot ? !n_drop : (fin_go && n_app);
	assign n_idx   = n_rot ? NIW'(n_cnt_q - 1'b1) : NIW'(n_cnt_q);
	assign n_wdata = n_rot ? n_head : {cmd_q.node_id, cmd_q.node_weight};
	assign e_rot   = (state_q == gnet_pkg::FSM_SCAN) && e_busy;
	assign e_wr    = e_rot ? !e_drop : (fin_go && e_app);
	assign e_idx   = e_rot ? EIW'(e_cnt_q - 1'b1) : EIW'(e_cnt_q);
	assign e_wdata = e_rot ? e_head
		: {cmd_q.from_node, cmd_q.to_node, cmd_q.edge_weight};

	gnet_ring #(.DEPTH(MAX_NODES), .W(64), .IW(NIW)) u_nodes (
		.clk(clk), .rot(n_rot), .wr_en(n_wr), .wr_idx(n_idx),
		.wr_data(n_wdata), .head(n_head)
	);

	gnet_ring #(.DEPTH(MAX_EDGES), .W(96), .IW(EIW)) u_edges (
		.clk(clk), .rot(e_rot), .wr_en(e_wr), .wr_idx(e_idx),
		.wr_data(e_wdata), .head(e_head)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gnet_pkg::FSM_IDLE: if (in_go) state_d = gnet_pkg::FSM_SCAN;
			gnet_pkg::FSM_SCAN: if (!n_busy && !e_busy) state_d = gnet_pkg::FSM_FIN;
			gnet_pkg::FSM_FIN:  if (fin_go) state_d = gnet_pkg::FSM_IDLE;
			default:            state_d = gnet_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gnet_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= gnet_pkg::NODE_LIMIT_RESET;
			n_cnt_q     <= '0;
			e_cnt_q     <= '0;
			n_left_q    <= '0;
			e_left_q    <= '0;
			out_valid_q <= 1'b0;
			early_q     <= 1'b0;
			found_n_q   <= 1'b0;
			hit_a_q     <= 1'b0;
			hit_b_q     <= 1'b0;
			found_e_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_go) begin
				found_n_q <= 1'b0;
				hit_a_q   <= 1'b0;
				hit_b_q   <= 1'b0;
				found_e_q <= 1'b0;
				early_q   <= (in_data.cmd == gnet_pkg::CMD_ADD_NODE && lim)
					|| (in_data.cmd == gnet_pkg::CMD_ADD_EDGE && under2);
				n_left_q  <= ((in_data.cmd == gnet_pkg::CMD_ADD_NODE && !lim)
					|| in_data.cmd == gnet_pkg::CMD_REM_NODE
					|| (in_data.cmd == gnet_pkg::CMD_ADD_EDGE && !under2)) ? n_cnt_q : '0;
				e_left_q  <= ((in_data.cmd == gnet_pkg::CMD_ADD_EDGE && !under2)
					|| in_data.cmd == gnet_pkg::CMD_REM_EDGE) ? e_cnt_q : '0;
			end
			if (n_rot) begin
				n_left_q <= n_left_q - 1'b1;
				if (n_match) found_n_q <= 1'b1;
				if (n_head[63:32] == cmd_q.from_node) hit_a_q <= 1'b1;
				if (n_head[63:32] == cmd_q.to_node) hit_b_q <= 1'b1;
				if (n_drop) n_cnt_q <= n_cnt_q - 1'b1;
			end
			if (e_rot) begin
				e_left_q <= e_left_q - 1'b1;
				if (e_hit) found_e_q <= 1'b1;
				if (e_drop) e_cnt_q <= e_cnt_q - 1'b1;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (n_app) n_cnt_q <= n_cnt_q + 1'b1;
				if (e_app) e_cnt_q <= e_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			cmd_q <= in_data;
		end
		if (fin_go) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

/* rtl/gnet_cell.sv */
// gnet_cell: one table entry, takes its upper neighbor on a rotate step
// or a direct write at its own index; no dependencies
`default_nettype none
module gnet_cell #(
	parameter int W   = 64,
	parameter int IW  = 7,
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          rot,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_idx,
	input  wire logic [W-1:0]  wr_data,
	input  wire logic [W-1:0]  nxt,
	output logic      [W-1:0]  q
);

	logic [W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == IW'(IDX)) begin
			data_q <= wr_data;
		end else if (rot) begin
			data_q <= nxt;
		end
	end

	assign q = data_q;

endmodule
`default_nettype wire

/* rtl/gnet_ring.sv */
// gnet_ring: chain of gnet_cell entries that shifts toward the head on rotate;
// the popped head is written back at the tail through the write port; uses gnet_cell
`default_nettype none
module gnet_ring #(
	parameter int DEPTH = 128,
	parameter int W     = 64,
	parameter int IW    = 7
) (
	input  wire logic          clk,
	input  wire logic          rot,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_idx,
	input  wire logic [W-1:0]  wr_data,
	output logic      [W-1:0]  head
);

	logic [W-1:0] q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = q[i];
		end else begin : g_mid
			assign nxt = q[i+1];
		end
		gnet_cell #(.W(W), .IW(IW), .IDX(i)) u_cell (
			.clk    (clk),
			.rot    (rot),
			.wr_en  (wr_en),
			.wr_idx (wr_idx),
			.wr_data(wr_data),
			.nxt    (nxt),
			.q      (q[i])
		);
	end

	assign head = q[0];

endmodule
`default_nettype wire

/* rtl/gnet_checker.sv */
// gnet_checker: port-level checks on graph_node_edge_table results
// uses gnet_pkg; bound to the top level below
`default_nettype none
module gnet_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire gnet_pkg::out_t out_data
);

	// pending item holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item dropped or changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= gnet_pkg::ST_EDGE_FULL)
		else $error("status code out of range");

	// seen flag only on add edge past the two-node check
	a_seen_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.edge_seen_before |->
			out_data.status == gnet_pkg::ST_DONE
			|| out_data.status == gnet_pkg::ST_BOTH_MISS
			|| out_data.status == gnet_pkg::ST_FROM_MISS
			|| out_data.status == gnet_pkg::ST_TO_MISS
			|| out_data.status == gnet_pkg::ST_EDGE_FULL)
		else $error("edge_seen_before with wrong status");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted without taking a work cycle");

endmodule

bind graph_node_edge_table gnet_checker u_gnet_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
`default_nettype wire
